// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants for the two-sum pair finder.
// Word structs, result status codes, controller states and the cell control struct.
// No dependencies; compile first.
package tsp_pkg;

	localparam int MAX_ITEMS_DEF = 256;
	localparam int VALUE_W       = 32;
	localparam int POS_W         = 8;
	localparam int STAT_W        = 2;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_FOUND    = 2'd0,
		ST_NO_PAIR  = 2'd1,
		ST_OVERFLOW = 2'd2
	} tsp_status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} tsp_state_t;

	// Input word
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} tsp_item_t;

	// Result word
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  first_position;
		logic [POS_W-1:0]  second_position;
	} tsp_result_t;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic shift;
		logic tok_clear;
	} tsp_cell_ctrl_t;

endpackage

// ===== hw/rtl/tsp_cell.sv =====
// One cell of the pair finder chain: a stored value, a search token and a compare.
// Values shift towards older cells on a store; the token walks one cell per cycle.
// Depends on tsp_pkg.
module tsp_cell
	import tsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tsp_cell_ctrl_t     ctrl,
	input  logic [VALUE_W-1:0] data_in,
	input  logic               tok_in,
	input  logic [VALUE_W-1:0] need,
	output logic [VALUE_W-1:0] data_out,
	output logic               tok_out,
	output logic               hit
);

	logic [VALUE_W-1:0] data_q;
	logic               tok_q;

	// Take the neighbour's value when the chain shifts
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= data_in;
		end
	end

	// Pass the search token along, drop it when the search ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctrl.tok_clear) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	// Flag a match while holding the token
	assign hit      = tok_q & (data_q == need);
	assign data_out = data_q;
	assign tok_out  = tok_q;

endmodule

// ===== hw/rtl/two_sum_pair_finder_core.sv =====
// Top level of the two-sum pair finder: controller plus a chain of MAX_ITEMS cells.
// Each stored value sits in a cell, newest in cell 0; a token walks the chain to search.
// Depends on tsp_pkg and tsp_cell.
//
// The block takes one word at a time. An item whose partner must be searched for goes
// from S_IDLE through S_SEARCH, where the search token passes k cells before it finds
// the partner (k is at most the number of values stored so far, minus one), to S_FINISH:
// the token moves one cell per cycle from the newest entry towards the oldest, so the
// most recent match is found first. An item that needs no search (empty store, store
// full, partner outside the 32-bit range, or a pair already found) goes from S_IDLE
// straight to S_FINISH. A finished result waits in an output register while the next
// word is taken; the block stalls only if a second result is ready before the first has
// been read. The store is emptied by resetting its fill count, so no clearing pass is
// needed after reset or after a last word.
module two_sum_pair_finder_core
	import tsp_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  tsp_item_t          item,
	output logic               result_valid,
	input  logic               result_ready,
	output tsp_result_t        result,
	input  logic               cfg_wr_en,
	input  logic [VALUE_W-1:0] cfg_wr_data
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int KW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	tsp_state_t state_q, state_d;

	logic signed [VALUE_W-1:0] target_q;
	logic [CW-1:0]             cnt_q;
	logic [KW-1:0]             k_q;
	logic                      pdone_q;
	logic                      cap_q;

	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] need_q;
	logic               last_q;
	logic               skip_q;
	logic               over_q;
	logic               found_q;
	logic [POS_W-1:0]   hitpos_q;

	logic        out_valid_q;
	tsp_result_t out_q;

	logic signed [VALUE_W:0] need_full;
	logic                    need_ok;
	logic                    accept;
	logic                    store_full;
	logic                    start_search;
	logic                    last_k;
	logic                    srch_end;
	logic                    emit;
	logic                    fin_go;
	logic                    do_store;
	logic                    any_hit;
	tsp_cell_ctrl_t          cell_ctrl;
	tsp_status_t             fin_status;

	logic [VALUE_W-1:0]   data_vec [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] tok_vec;
	logic [MAX_ITEMS-1:0] hit_vec;

	// Partner value, computed one bit wider so it cannot wrap
	assign need_full = {target_q[VALUE_W-1], target_q} - {item.value[VALUE_W-1], item.value};
	assign need_ok   = (need_full[VALUE_W] == need_full[VALUE_W-1]);

	// Handshake and control decode
	always_comb begin
		item_ready   = (state_q == S_IDLE);
		accept       = item_valid & item_ready;
		store_full   = (cnt_q == CW'(MAX_ITEMS));
		start_search = accept & ~pdone_q & ~store_full & need_ok & (cnt_q != '0);
		last_k       = (CW'(k_q) == (cnt_q - CW'(1)));
		srch_end     = (state_q == S_SEARCH) & (any_hit | last_k);
		emit         = ~skip_q & (found_q | last_q);
		fin_go       = (state_q == S_FINISH) & (~emit | ~out_valid_q | result_ready);
		do_store     = fin_go & ~skip_q & ~over_q & ~found_q;
		cell_ctrl.shift     = do_store;
		cell_ctrl.tok_clear = srch_end;
		if (found_q) begin
			fin_status = ST_FOUND;
		end else if (cap_q | over_q) begin
			fin_status = ST_OVERFLOW;
		end else begin
			fin_status = ST_NO_PAIR;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = start_search ? S_SEARCH : S_FINISH;
				end
			end
			S_SEARCH: begin
				if (srch_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Chain of cells, newest value in cell 0
	for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
		if (c == 0) begin : g_head
			tsp_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.data_in  (value_q),
				.tok_in   (start_search),
				.need     (need_q),
				.data_out (data_vec[c]),
				.tok_out  (tok_vec[c]),
				.hit      (hit_vec[c])
			);
		end else begin : g_body
			tsp_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.data_in  (data_vec[c-1]),
				.tok_in   (tok_vec[c-1]),
				.need     (need_q),
				.data_out (data_vec[c]),
				.tok_out  (tok_vec[c]),
				.hit      (hit_vec[c])
			);
		end
	end

	assign any_hit = |hit_vec;

	// Hold the word being worked on
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= item.value;
			need_q  <= need_full[VALUE_W-1:0];
			last_q  <= item.last;
		end
		if ((state_q == S_SEARCH) && any_hit) begin
			hitpos_q <= POS_W'(cnt_q - CW'(1) - CW'(k_q));
		end
		if (fin_go && emit) begin
			out_q.status          <= fin_status;
			out_q.first_position  <= found_q ? hitpos_q : '0;
			out_q.second_position <= found_q ? POS_W'(cnt_q) : '0;
		end
	end

	// Controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			target_q    <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			pdone_q     <= 1'b0;
			cap_q       <= 1'b0;
			skip_q      <= 1'b0;
			over_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			// Latch the per-word flags on acceptance
			if (accept) begin
				skip_q  <= pdone_q;
				over_q  <= ~pdone_q & store_full;
				found_q <= 1'b0;
				k_q     <= '0;
			end
			// Advance the token count, or record the match
			if (state_q == S_SEARCH) begin
				if (any_hit) begin
					found_q <= 1'b1;
				end else if (!last_k) begin
					k_q <= KW'(k_q + 1'b1);
				end
			end
			// Commit the word; a last word empties the store
			if (fin_go) begin
				if (do_store) begin
					cnt_q <= CW'(cnt_q + 1'b1);
				end
				if (!skip_q && found_q) begin
					pdone_q <= 1'b1;
				end
				if (over_q) begin
					cap_q <= 1'b1;
				end
				if (last_q) begin
					cnt_q   <= '0;
					pdone_q <= 1'b0;
					cap_q   <= 1'b0;
				end
			end
			// Output register
			if (fin_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one search token in the chain");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (CW'(k_q) < cnt_q))
		else $error("search token beyond the stored entries");

	a_hit_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit |-> (state_q == S_SEARCH))
		else $error("match flagged outside a search");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("fill count above capacity");

	a_store_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && last_q) |=> (cnt_q == '0) && !pdone_q && !cap_q)
		else $error("store not emptied after a last word");
`endif

endmodule
